[hdl/ladsr_pkg.sv]
// Shared types and constants for the linear ADSR envelope generator.
package ladsr_pkg;

   // Configuration register indexes.
   localparam int CSR_ADDR_W = 3;
   localparam logic [CSR_ADDR_W-1:0] CSR_ATTACK_LEVEL  = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_DECAY_LEVEL   = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_SUSTAIN_LEVEL = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_RELEASE_LEVEL = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_ATTACK_TICKS  = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_DECAY_TICKS   = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] CSR_RELEASE_TICKS = 3'd6;

   // Reset length of every ramp, in sample ticks.
   localparam int TICKS_RESET = 48;

   // Envelope stage codes as seen on the result channel.
   localparam int STAGE_W = 3;
   localparam logic [STAGE_W-1:0] STAGE_ATTACK       = 3'd0;
   localparam logic [STAGE_W-1:0] STAGE_DECAY        = 3'd1;
   localparam logic [STAGE_W-1:0] STAGE_SUSTAIN      = 3'd2;
   localparam logic [STAGE_W-1:0] STAGE_RELEASE      = 3'd3;
   localparam logic [STAGE_W-1:0] STAGE_RELEASE_DONE = 3'd4;

   // Input channel data width (fields padded to whole bytes).
   localparam int REQ_DATA_W = 8;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PREP,
      ST_ATK,
      ST_DCY,
      ST_REL,
      ST_MUL,
      ST_DIV,
      ST_FIN,
      ST_FALL,
      ST_OUT
   } state_type;

endpackage

[hdl/linear_adsr_envelope.sv]
// Linear ADSR envelope generator: one gate bit in, one level and stage out per sample tick.
// Each accepted gate passes through the sequencer states and ends in one result transaction;
// a ramp point costs one multiply and LEVEL_BITS+1 restoring divide steps.
// The next gate is taken only once the previous result has been delivered; stalls on the
// result channel delay both the result and the acceptance of the next gate.
// Reset (synchronous, active high) clears the tick state, zeroes the levels, ramps to 48 ticks.
module linear_adsr_envelope #(
   parameter int TIME_BITS  = 24,
   parameter int LEVEL_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // Input channel.
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [ladsr_pkg::REQ_DATA_W-1:0]      req_tdata,  // [0] gate_on
   // Result channel.
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [((LEVEL_BITS+ladsr_pkg::STAGE_W+7)/8)*8-1:0]
                                                 rsp_tdata,  // level, then stage
   // Configuration write port.
   input  logic                                  csr_we,
   input  logic [ladsr_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [(TIME_BITS > LEVEL_BITS ? TIME_BITS : LEVEL_BITS)-1:0]
                                                 csr_wdata
);

   import ladsr_pkg::*;

   localparam int LB    = LEVEL_BITS;
   localparam int TB    = TIME_BITS;
   localparam int W     = TB + LB + 1;
   localparam int RSP_W = ((LB + STAGE_W + 7) / 8) * 8;
   localparam int CNT_W = $clog2(LB + 1);

   // Configuration registers.
   logic [LB-1:0] attack_level_ff, decay_level_ff, sustain_level_ff, release_level_ff;
   logic [TB-1:0] attack_ticks_ff, decay_ticks_ff, release_ticks_ff;

   // Control state.
   state_type     state_ff, state_in;
   logic [TB-1:0] elapsed_ff, elapsed_in;
   logic          prev_gate_ff, prev_gate_in;
   logic [LB-1:0] rs_ff, rs_in;

   // Working registers of the sequencer.
   logic               gate_ff, gate_in;
   logic               falling_ff, falling_in;
   logic [TB-1:0]      tev_ff, tev_in;
   logic [LB-1:0]      a_ff, a_in;
   logic [LB-1:0]      b_ff, b_in;
   logic [TB-1:0]      den_ff, den_in;
   logic [STAGE_W-1:0] stage_ff, stage_in;
   logic [LB-1:0]      level_ff, level_in;
   logic               neg_ff, neg_in;
   logic [W-1:0]       rem_ff, rem_in;
   logic [W-1:0]       dvs_ff, dvs_in;
   logic [LB:0]        quo_ff, quo_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;

   // Combinational helpers.
   logic [TB-1:0] t_inc;
   logic [TB-1:0] t_inc2;
   logic [LB:0]   diff;
   logic [LB:0]   mag;
   logic [LB+1:0] ax;
   logic [LB+1:0] mx;
   logic [LB+1:0] res;
   logic          rem_ge;

   always_ff @(posedge clock) begin
      if (reset) begin
         attack_level_ff  <= '0;
         decay_level_ff   <= '0;
         sustain_level_ff <= '0;
         release_level_ff <= '0;
         attack_ticks_ff  <= TB'(TICKS_RESET);
         decay_ticks_ff   <= TB'(TICKS_RESET);
         release_ticks_ff <= TB'(TICKS_RESET);
      end else if (csr_we) begin
         case (csr_addr)
            CSR_ATTACK_LEVEL:  attack_level_ff  <= csr_wdata[LB-1:0];
            CSR_DECAY_LEVEL:   decay_level_ff   <= csr_wdata[LB-1:0];
            CSR_SUSTAIN_LEVEL: sustain_level_ff <= csr_wdata[LB-1:0];
            CSR_RELEASE_LEVEL: release_level_ff <= csr_wdata[LB-1:0];
            CSR_ATTACK_TICKS:  attack_ticks_ff  <= csr_wdata[TB-1:0];
            CSR_DECAY_TICKS:   decay_ticks_ff   <= csr_wdata[TB-1:0];
            CSR_RELEASE_TICKS: release_ticks_ff <= csr_wdata[TB-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         elapsed_ff   <= '0;
         prev_gate_ff <= 1'b0;
         rs_ff        <= '0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         elapsed_ff   <= elapsed_in;
         prev_gate_ff <= prev_gate_in;
         rs_ff        <= rs_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      gate_ff    <= gate_in;
      falling_ff <= falling_in;
      tev_ff     <= tev_in;
      a_ff       <= a_in;
      b_ff       <= b_in;
      den_ff     <= den_in;
      stage_ff   <= stage_in;
      level_ff   <= level_in;
      neg_ff     <= neg_in;
      rem_ff     <= rem_in;
      dvs_ff     <= dvs_in;
      quo_ff     <= quo_in;
   end

   always_comb begin
      // Saturating increments of the tick counter.
      t_inc  = (elapsed_ff == {TB{1'b1}}) ? elapsed_ff : elapsed_ff + 1'b1;
      t_inc2 = (t_inc == {TB{1'b1}}) ? t_inc : t_inc + 1'b1;

      diff   = {b_ff[LB-1], b_ff} - {a_ff[LB-1], a_ff};
      mag    = diff[LB] ? (~diff + 1'b1) : diff;
      rem_ge = (rem_ff >= dvs_ff);

      // Floor of the signed ramp: a negative slope rounds its magnitude up.
      ax  = {a_ff[LB-1], a_ff[LB-1], a_ff};
      mx  = {1'b0, quo_ff} + (LB+2)'(neg_ff && (rem_ff != '0));
      res = neg_ff ? (ax - mx) : (ax + mx);

      state_in     = state_ff;
      elapsed_in   = elapsed_ff;
      prev_gate_in = prev_gate_ff;
      rs_in        = rs_ff;
      cnt_in       = cnt_ff;
      gate_in      = gate_ff;
      falling_in   = falling_ff;
      tev_in       = tev_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      den_in       = den_ff;
      stage_in     = stage_ff;
      level_in     = level_ff;
      neg_in       = neg_ff;
      rem_in       = rem_ff;
      dvs_in       = dvs_ff;
      quo_in       = quo_ff;

      req_tready = 1'b0;
      rsp_tvalid = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               gate_in  = req_tdata[0];
               state_in = ST_PREP;
            end
         end

         ST_PREP: begin
            falling_in   = !gate_ff && prev_gate_ff;
            elapsed_in   = (gate_ff != prev_gate_ff) ? '0 : t_inc;
            prev_gate_in = gate_ff;
            if (!gate_ff && prev_gate_ff) begin
               // The release start is the held envelope one tick further on.
               tev_in   = t_inc2;
               state_in = ST_ATK;
            end else if (gate_ff) begin
               tev_in   = (gate_ff != prev_gate_ff) ? '0 : t_inc;
               state_in = ST_ATK;
            end else begin
               tev_in   = t_inc;
               state_in = ST_REL;
            end
         end

         ST_ATK: begin
            if (attack_ticks_ff > tev_ff) begin
               stage_in = STAGE_ATTACK;
               a_in     = attack_level_ff;
               b_in     = decay_level_ff;
               den_in   = attack_ticks_ff;
               state_in = ST_MUL;
            end else begin
               tev_in   = tev_ff - attack_ticks_ff;
               state_in = ST_DCY;
            end
         end

         ST_DCY: begin
            if (decay_ticks_ff > tev_ff) begin
               stage_in = STAGE_DECAY;
               a_in     = decay_level_ff;
               b_in     = sustain_level_ff;
               den_in   = decay_ticks_ff;
               state_in = ST_MUL;
            end else begin
               stage_in = STAGE_SUSTAIN;
               level_in = sustain_level_ff;
               if (falling_ff) begin
                  rs_in    = sustain_level_ff;
                  state_in = ST_FALL;
               end else begin
                  state_in = ST_OUT;
               end
            end
         end

         ST_REL: begin
            if (release_ticks_ff > tev_ff) begin
               stage_in = STAGE_RELEASE;
               a_in     = rs_ff;
               b_in     = release_level_ff;
               den_in   = release_ticks_ff;
               state_in = ST_MUL;
            end else begin
               stage_in = STAGE_RELEASE_DONE;
               level_in = release_level_ff;
               state_in = ST_OUT;
            end
         end

         ST_MUL: begin
            neg_in   = diff[LB];
            rem_in   = W'(mag) * W'(tev_ff);
            dvs_in   = {1'b0, den_ff, {LB{1'b0}}};
            quo_in   = '0;
            cnt_in   = CNT_W'(LB);
            state_in = ST_DIV;
         end

         ST_DIV: begin
            // One restoring step per cycle; the quotient is below 2**(LB+1).
            if (rem_ge) begin
               rem_in = rem_ff - dvs_ff;
            end
            quo_in = {quo_ff[LB-1:0], rem_ge};
            dvs_in = dvs_ff >> 1;
            if (cnt_ff == '0) begin
               state_in = ST_FIN;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end

         ST_FIN: begin
            level_in = res[LB-1:0];
            if (falling_ff) begin
               rs_in    = res[LB-1:0];
               state_in = ST_FALL;
            end else begin
               state_in = ST_OUT;
            end
         end

         ST_FALL: begin
            // At the first release tick the ramp stands at its start level.
            if (release_ticks_ff != '0) begin
               stage_in = STAGE_RELEASE;
               level_in = rs_ff;
            end else begin
               stage_in = STAGE_RELEASE_DONE;
               level_in = release_level_ff;
            end
            state_in = ST_OUT;
         end

         ST_OUT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_tdata = RSP_W'({stage_ff, level_ff});

endmodule
